// ===== rtl/ppg_pkg.sv =====
// Shared types, constants and sine tables of the plasma pixel generator.
`timescale 1ns / 1ps
`default_nettype none
package ppg_pkg;

   localparam int COORD_W  = 10;
   localparam int STEP_W   = 20;
   localparam int TIME_W   = 24;
   localparam int TMUL_W   = 25;
   localparam int ARG_W    = 27;
   localparam int PLASMA_W = 20;
   localparam int D2_W     = 22;
   localparam int DIST_W   = 11;
   localparam int IDX_W    = 7;
   localparam int COLOR_W  = 16;

   // Scale constants, round(c * 2^16).
   localparam logic [11:0] K_X   = 12'd2621;
   localparam logic [10:0] K_Y   = 11'd1966;
   localparam logic [16:0] K_07  = 17'd45875;
   localparam logic [16:0] K_12  = 17'd78643;
   localparam logic [11:0] K_05D = 12'd3277;
   localparam logic [16:0] K_05  = 17'd32768;
   localparam logic [16:0] K_03  = 17'd19661;
   localparam logic [17:0] K_133 = 18'd87163;
   localparam logic [17:0] K_266 = 18'd174326;
   localparam logic [TIME_W:0] TIME_WRAP = 25'd13107200;

   // Phase divisor 710 * 2^16 / 128 = 363520 and its reciprocal 2^32 / 363520.
   localparam logic [18:0] PH_DIV = 19'd363520;
   localparam logic [13:0] PH_REC = 14'd11814;
   localparam logic [6:0]  PH_MUL = 7'd113;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [STEP_W-1:0]  time_step;
   } item_type;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   function automatic logic [15:0] quarter_sine(input logic [5:0] m);
      logic [15:0] v;
      case (m)
         6'd0: v = 16'd0;      6'd1: v = 16'd1608;   6'd2: v = 16'd3212;   6'd3: v = 16'd4808;
         6'd4: v = 16'd6393;   6'd5: v = 16'd7962;   6'd6: v = 16'd9512;   6'd7: v = 16'd11039;
         6'd8: v = 16'd12540;  6'd9: v = 16'd14010;  6'd10: v = 16'd15447; 6'd11: v = 16'd16846;
         6'd12: v = 16'd18205; 6'd13: v = 16'd19520; 6'd14: v = 16'd20788; 6'd15: v = 16'd22006;
         6'd16: v = 16'd23170; 6'd17: v = 16'd24279; 6'd18: v = 16'd25330; 6'd19: v = 16'd26320;
         6'd20: v = 16'd27246; 6'd21: v = 16'd28106; 6'd22: v = 16'd28899; 6'd23: v = 16'd29622;
         6'd24: v = 16'd30274; 6'd25: v = 16'd30853; 6'd26: v = 16'd31357; 6'd27: v = 16'd31786;
         6'd28: v = 16'd32138; 6'd29: v = 16'd32413; 6'd30: v = 16'd32610; 6'd31: v = 16'd32729;
         6'd32: v = 16'd32768;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] byte_sine(input logic [6:0] i);
      logic [7:0] v;
      case (i)
         7'd0: v = 8'd128;   7'd1: v = 8'd134;   7'd2: v = 8'd140;   7'd3: v = 8'd146;
         7'd4: v = 8'd152;   7'd5: v = 8'd158;   7'd6: v = 8'd165;   7'd7: v = 8'd170;
         7'd8: v = 8'd176;   7'd9: v = 8'd182;   7'd10: v = 8'd188;  7'd11: v = 8'd193;
         7'd12: v = 8'd198;  7'd13: v = 8'd203;  7'd14: v = 8'd208;  7'd15: v = 8'd213;
         7'd16: v = 8'd218;  7'd17: v = 8'd222;  7'd18: v = 8'd226;  7'd19: v = 8'd230;
         7'd20: v = 8'd234;  7'd21: v = 8'd237;  7'd22: v = 8'd240;  7'd23: v = 8'd243;
         7'd24: v = 8'd245;  7'd25: v = 8'd248;  7'd26: v = 8'd250;  7'd27: v = 8'd251;
         7'd28: v = 8'd253;  7'd29: v = 8'd254;  7'd30: v = 8'd254;  7'd31: v = 8'd255;
         7'd32: v = 8'd255;  7'd33: v = 8'd255;  7'd34: v = 8'd254;  7'd35: v = 8'd254;
         7'd36: v = 8'd253;  7'd37: v = 8'd251;  7'd38: v = 8'd250;  7'd39: v = 8'd248;
         7'd40: v = 8'd245;  7'd41: v = 8'd243;  7'd42: v = 8'd240;  7'd43: v = 8'd237;
         7'd44: v = 8'd234;  7'd45: v = 8'd230;  7'd46: v = 8'd226;  7'd47: v = 8'd222;
         7'd48: v = 8'd218;  7'd49: v = 8'd213;  7'd50: v = 8'd208;  7'd51: v = 8'd203;
         7'd52: v = 8'd198;  7'd53: v = 8'd193;  7'd54: v = 8'd188;  7'd55: v = 8'd182;
         7'd56: v = 8'd176;  7'd57: v = 8'd170;  7'd58: v = 8'd165;  7'd59: v = 8'd158;
         7'd60: v = 8'd152;  7'd61: v = 8'd146;  7'd62: v = 8'd140;  7'd63: v = 8'd134;
         7'd64: v = 8'd128;  7'd65: v = 8'd121;  7'd66: v = 8'd115;  7'd67: v = 8'd109;
         7'd68: v = 8'd103;  7'd69: v = 8'd97;   7'd70: v = 8'd90;   7'd71: v = 8'd85;
         7'd72: v = 8'd79;   7'd73: v = 8'd73;   7'd74: v = 8'd67;   7'd75: v = 8'd62;
         7'd76: v = 8'd57;   7'd77: v = 8'd52;   7'd78: v = 8'd47;   7'd79: v = 8'd42;
         7'd80: v = 8'd37;   7'd81: v = 8'd33;   7'd82: v = 8'd29;   7'd83: v = 8'd25;
         7'd84: v = 8'd21;   7'd85: v = 8'd18;   7'd86: v = 8'd15;   7'd87: v = 8'd12;
         7'd88: v = 8'd10;   7'd89: v = 8'd7;    7'd90: v = 8'd5;    7'd91: v = 8'd4;
         7'd92: v = 8'd2;    7'd93: v = 8'd1;    7'd94: v = 8'd1;    7'd95: v = 8'd0;
         7'd96: v = 8'd0;    7'd97: v = 8'd0;    7'd98: v = 8'd1;    7'd99: v = 8'd1;
         7'd100: v = 8'd2;   7'd101: v = 8'd4;   7'd102: v = 8'd5;   7'd103: v = 8'd7;
         7'd104: v = 8'd10;  7'd105: v = 8'd12;  7'd106: v = 8'd15;  7'd107: v = 8'd18;
         7'd108: v = 8'd21;  7'd109: v = 8'd25;  7'd110: v = 8'd29;  7'd111: v = 8'd33;
         7'd112: v = 8'd37;  7'd113: v = 8'd42;  7'd114: v = 8'd47;  7'd115: v = 8'd52;
         7'd116: v = 8'd57;  7'd117: v = 8'd62;  7'd118: v = 8'd67;  7'd119: v = 8'd73;
         7'd120: v = 8'd79;  7'd121: v = 8'd85;  7'd122: v = 8'd90;  7'd123: v = 8'd97;
         7'd124: v = 8'd103; 7'd125: v = 8'd109; 7'd126: v = 8'd115; 7'd127: v = 8'd121;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ppg_queue.sv =====
// Front part: two-entry item queue between the request port and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module ppg_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ppg_pkg::item_type push_item,
   output logic                   full,
   output logic                   item_valid,
   output ppg_pkg::item_type      item,
   input  wire logic              pop
);

   ppg_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = mem_ff[rd_ptr_ff];
   assign do_pop     = pop & item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ppg_root.sv =====
// Iterative rounded square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ppg_root (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ppg_pkg::D2_W-1:0]  d2,
   output logic                           done,
   output logic [ppg_pkg::DIST_W-1:0]     radius
);

   localparam int W = ppg_pkg::D2_W;

   logic [W-1:0] n_ff, n_in;
   logic [W-1:0] r_ff, r_in;
   logic [W-1:0] bit_ff, bit_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic         small_ff, small_in;
   logic [W:0]   trial;

   always_comb begin
      trial    = {1'b0, r_ff} + {1'b0, bit_ff};
      n_in     = n_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      small_in = small_ff;
      if (start) begin
         n_in     = d2;
         r_in     = '0;
         bit_in   = W'(1) << (W - 2);
         busy_in  = 1'b1;
         done_in  = 1'b0;
         small_in = (d2 < W'(2));
      end else if (busy_ff) begin
         if ({1'b0, n_ff} >= trial) begin
            n_in = n_ff - trial[W-1:0];
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      r_ff     <= r_in;
      bit_ff   <= bit_in;
      small_ff <= small_in;
   end

   // Round up when the remainder exceeds the root; a radicand below 2 gives 1.
   assign done   = done_ff;
   assign radius = small_ff ? ppg_pkg::DIST_W'(1)
                            : r_ff[ppg_pkg::DIST_W-1:0] + ppg_pkg::DIST_W'(n_ff > r_ff);

endmodule
`default_nettype wire

// ===== rtl/ppg_phase.sv =====
// Pipelined phase index: signed argument divided by a constant, truncated, masked to 7 bits.
`timescale 1ns / 1ps
`default_nettype none
module ppg_phase (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire logic signed [ppg_pkg::ARG_W-1:0] arg,
   output logic                                  out_valid,
   output logic [ppg_pkg::IDX_W-1:0]             idx
);

   localparam int AW = ppg_pkg::ARG_W;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [32:0] n1_ff, n2_ff;
   logic [46:0] prod2_ff;
   logic [14:0] q0_3_ff;
   logic [34:0] rem3_ff;
   logic [6:0]  idx_ff, idx_in;
   logic [AW-1:0] mag;
   logic [14:0]  q0;
   logic [6:0]   q;

   always_comb begin
      mag    = arg[AW-1] ? (~arg + AW'(1)) : arg;
      q0     = prod2_ff[46:32];
      q      = q0_3_ff[6:0] + 7'(rem3_ff >= {16'd0, ppg_pkg::PH_DIV});
      idx_in = neg3_ff ? (~q + 7'd1) : q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg1_ff  <= arg[AW-1];
      n1_ff    <= 33'(mag * ppg_pkg::PH_MUL);
      neg2_ff  <= neg1_ff;
      n2_ff    <= n1_ff;
      prod2_ff <= n1_ff * ppg_pkg::PH_REC;
      neg3_ff  <= neg2_ff;
      q0_3_ff  <= q0;
      rem3_ff  <= {2'b0, n2_ff} - 35'(q0 * ppg_pkg::PH_DIV);
      idx_ff   <= idx_in;
   end

   assign out_valid = v4_ff;
   assign idx       = idx_ff;

endmodule
`default_nettype wire

// ===== rtl/ppg_back.sv =====
// Back part: time keeping and the per-pixel sequencer with root and phase units.
`timescale 1ns / 1ps
`default_nettype none
module ppg_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         item_valid,
   input  wire ppg_pkg::item_type            item,
   output logic                              pop,
   input  wire logic [8:0]                   center_x,
   input  wire logic [8:0]                   center_y,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid,
   output logic [ppg_pkg::COLOR_W-1:0]       rsp_color
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PREP  = 5'b00010,
      ST_WAVE  = 5'b00100,
      ST_COLOR = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   localparam int AW = ppg_pkg::ARG_W;
   localparam int TW = ppg_pkg::TMUL_W;

   state_type state_ff, state_in;
   logic [ppg_pkg::TIME_W-1:0]    anim_ff, anim_in;
   logic [ppg_pkg::COORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [1:0]                    tcnt_ff, tcnt_in;
   logic                          tdone_ff, tdone_in;
   logic [TW-1:0]                 t07_ff, t12_ff, t05_ff, t03_ff;
   logic [2:0]                    icnt_ff, icnt_in, rcnt_ff, rcnt_in;
   logic signed [ppg_pkg::PLASMA_W-1:0] plasma_ff, plasma_in;
   logic [3:0]                    r_ff, b_ff;
   logic [4:0]                    g_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ppg_pkg::COLOR_W-1:0]   rsp_color_ff;

   logic [ppg_pkg::TIME_W:0]      tsum;
   logic [16:0]                   tk;
   logic [41:0]                   tprod;
   logic [TW-1:0]                 tmul;
   logic signed [10:0]            dx, dy;
   logic [ppg_pkg::D2_W-1:0]      d2;
   logic                          root_start, root_done;
   logic [ppg_pkg::DIST_W-1:0]    radius;
   logic [21:0]                   x1;
   logic [20:0]                   y1;
   logic [22:0]                   dscaled;
   logic signed [AW-1:0]          arg;
   logic                          ph_valid, ph_out_valid;
   logic [ppg_pkg::IDX_W-1:0]     ph_idx;
   logic [5:0]                    hph, mph;
   logic signed [ppg_pkg::PLASMA_W-1:0] wave;
   logic [7:0]                    bval;
   logic                          load_out;

   ppg_root u_root (
      .clock (clock), .reset (reset), .start (root_start), .d2 (d2),
      .done (root_done), .radius (radius)
   );

   ppg_phase u_phase (
      .clock (clock), .reset (reset), .in_valid (ph_valid), .arg (arg),
      .out_valid (ph_out_valid), .idx (ph_idx)
   );

   always_comb begin
      // time advance with a single wrap
      tsum = {1'b0, anim_ff} + {5'd0, item.time_step};
      // squared distance to the centre
      dx = $signed({1'b0, item.pos_x}) - $signed({2'b0, center_x});
      dy = $signed({1'b0, item.pos_y}) - $signed({2'b0, center_y});
      d2 = 22'(dx * dx) + 22'(dy * dy);
      case (tcnt_ff)
         2'd0:    tk = ppg_pkg::K_07;
         2'd1:    tk = ppg_pkg::K_12;
         2'd2:    tk = ppg_pkg::K_05;
         default: tk = ppg_pkg::K_03;
      endcase
      tprod = anim_ff * tk;
      tmul  = TW'((tprod + 42'd32768) >> 16);
      x1      = x_ff * ppg_pkg::K_X;
      y1      = y_ff * ppg_pkg::K_Y;
      dscaled = radius * ppg_pkg::K_05D;
      arg = '0;
      if (state_ff == ST_WAVE) begin
         case (icnt_ff)
            3'd0:    arg = $signed({5'd0, x1}) + $signed({3'd0, anim_ff});
            3'd1:    arg = $signed({6'd0, y1}) - $signed({2'd0, t07_ff});
            3'd2:    arg = $signed({5'd0, x1}) + $signed({6'd0, y1})
                           + $signed({2'd0, t12_ff});
            default: arg = $signed({4'd0, dscaled}) - $signed({2'd0, t05_ff});
         endcase
      end else begin
         case (icnt_ff)
            3'd0:    arg = AW'(plasma_ff) + $signed({2'd0, t03_ff});
            3'd1:    arg = AW'(plasma_ff) + $signed({2'd0, t05_ff})
                           + $signed({9'd0, ppg_pkg::K_133});
            default: arg = AW'(plasma_ff) + $signed({2'd0, t07_ff})
                           + $signed({9'd0, ppg_pkg::K_266});
         endcase
      end
      // signed wave value is twice the quarter-table entry
      hph  = ph_idx[5:0];
      mph  = (hph <= 6'd32) ? hph : (6'd0 - hph);
      wave = $signed({3'd0, ppg_pkg::quarter_sine(mph), 1'b0});
      if (ph_idx[6]) begin
         wave = -wave;
      end
      bval = ppg_pkg::byte_sine(ph_idx);
   end

   always_comb begin
      state_in   = state_ff;
      anim_in    = anim_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      tcnt_in    = tcnt_ff;
      tdone_in   = tdone_ff;
      icnt_in    = icnt_ff;
      rcnt_in    = rcnt_ff;
      plasma_in  = plasma_ff;
      pop        = 1'b0;
      root_start = 1'b0;
      ph_valid   = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               pop = 1'b1;
               if (item.mode == ppg_pkg::MODE_TICK) begin
                  anim_in = (tsum > ppg_pkg::TIME_WRAP)
                          ? ppg_pkg::TIME_W'(tsum - ppg_pkg::TIME_WRAP)
                          : tsum[ppg_pkg::TIME_W-1:0];
               end else begin
                  x_in       = item.pos_x;
                  y_in       = item.pos_y;
                  root_start = 1'b1;
                  tcnt_in    = 2'd0;
                  tdone_in   = 1'b0;
                  state_in   = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            if (!tdone_ff) begin
               tcnt_in = tcnt_ff + 2'd1;
               if (tcnt_ff == 2'd3) begin
                  tdone_in = 1'b1;
               end
            end else if (root_done) begin
               icnt_in   = 3'd0;
               rcnt_in   = 3'd0;
               plasma_in = '0;
               state_in  = ST_WAVE;
            end
         end
         ST_WAVE: begin
            if (icnt_ff < 3'd4) begin
               ph_valid = 1'b1;
               icnt_in  = icnt_ff + 3'd1;
            end
            if (ph_out_valid) begin
               plasma_in = plasma_ff + wave;
               rcnt_in   = rcnt_ff + 3'd1;
               if (rcnt_ff == 3'd3) begin
                  icnt_in  = 3'd0;
                  rcnt_in  = 3'd0;
                  state_in = ST_COLOR;
               end
            end
         end
         ST_COLOR: begin
            if (icnt_ff < 3'd3) begin
               ph_valid = 1'b1;
               icnt_in  = icnt_ff + 3'd1;
            end
            if (ph_out_valid) begin
               rcnt_in = rcnt_ff + 3'd1;
               if (rcnt_ff == 3'd2) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         anim_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         tcnt_ff      <= 2'd0;
         tdone_ff     <= 1'b0;
         icnt_ff      <= 3'd0;
         rcnt_ff      <= 3'd0;
      end else begin
         state_ff     <= state_in;
         anim_ff      <= anim_in;
         rsp_valid_ff <= rsp_valid_in;
         tcnt_ff      <= tcnt_in;
         tdone_ff     <= tdone_in;
         icnt_ff      <= icnt_in;
         rcnt_ff      <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      plasma_ff <= plasma_in;
      if (state_ff == ST_PREP && !tdone_ff) begin
         case (tcnt_ff)
            2'd0:    t07_ff <= tmul;
            2'd1:    t12_ff <= tmul;
            2'd2:    t05_ff <= tmul;
            default: t03_ff <= tmul;
         endcase
      end
      if (state_ff == ST_COLOR && ph_out_valid) begin
         case (rcnt_ff)
            3'd0:    r_ff <= bval[7:4];
            3'd1:    g_ff <= bval[7:3];
            default: b_ff <= bval[7:4];
         endcase
      end
      if (load_out) begin
         rsp_color_ff <= {r_ff, 1'b0, g_ff, 1'b0, b_ff, 1'b0};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_color = rsp_color_ff;

`ifndef SYNTHESIS
   a_time_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, anim_ff} <= ppg_pkg::TIME_WRAP)
      else $error("animation time above wrap point");
   a_phase_in_use: assert property (@(posedge clock) disable iff (reset)
      ph_out_valid |-> (state_ff == ST_WAVE || state_ff == ST_COLOR))
      else $error("phase result outside wave or color step");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not presented after load");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE)
      else $error("item taken while busy");
`endif

endmodule
`default_nettype wire

// ===== rtl/plasma_pixel_generator_core.sv =====
// Plasma pixel generator top level: request queue, sequencer and register port.
// Tick item: popped from the queue by the idle sequencer, when the new time applies.
// Pixel item: popped, then the 11-step root runs while the four time products are formed;
//   then four and then three arguments pass the 4-stage phase unit and the result is loaded.
// Throughput: pixel items one at a time; one tick item per cycle when the sequencer idles.
// Reset (synchronous, active high): clears time, queue and handshakes; sizes return to 240.
`timescale 1ns / 1ps
`default_nettype none
module plasma_pixel_generator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [9:0]  req_pos_x,
   input  wire logic [9:0]  req_pos_y,
   input  wire logic [19:0] req_time_step,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_color,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // register indexes by word address
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   ppg_pkg::item_type push_item, item;
   logic       push, full, item_valid, pop;
   logic [9:0] width_ff, width_in, height_ff, height_in;
   logic       csr_write;

   assign push_item = '{mode: req_mode, pos_x: req_pos_x, pos_y: req_pos_y,
                        time_step: req_time_step};
   assign push      = req_valid & ~full;
   assign req_stall = full;

   // Accept and hold items ahead of the sequencer.
   ppg_queue u_queue (
      .clock (clock), .reset (reset), .push (push), .push_item (push_item),
      .full (full), .item_valid (item_valid), .item (item), .pop (pop)
   );

   // Carry out ticks and pixels; centre is half the screen size.
   ppg_back u_back (
      .clock (clock), .reset (reset), .item_valid (item_valid), .item (item), .pop (pop),
      .center_x (width_ff[9:1]), .center_y (height_ff[9:1]),
      .rsp_stall (rsp_stall), .rsp_valid (rsp_valid), .rsp_color (rsp_color)
   );

   // Register port: zero wait states, write on the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_WIDTH:  width_in  = csr_pwdata[9:0];
            REG_HEIGHT: height_in = csr_pwdata[9:0];
            default:    width_in  = width_ff;
         endcase
      end
      csr_prdata = (csr_paddr[2] == REG_HEIGHT) ? {22'd0, height_ff} : {22'd0, width_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'd240;
         height_ff <= 10'd240;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

endmodule
`default_nettype wire
